[hw/rtl/bfifo_pkg.sv]
// Shared types and constants of the byte FIFO with frame counting.
`default_nettype none
package bfifo_pkg;

  // Operation codes carried by an input transfer.
  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Control sequencer states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_DELIM = 3'd0;
  localparam logic [7:0] DELIM_RESET = 8'd10;

  // Status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

endpackage
`default_nettype wire

[hw/rtl/bfifo_ram.sv]
// Byte store: single write port, single read port, registered read data.
`default_nettype none
module bfifo_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bfifo_cfg.sv]
// Configuration register bank holding the frame delimiter byte.
`default_nettype none
module bfifo_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bfifo_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready,
  output logic      [7:0]                       delim
);

  logic [7:0] delim_r;
  logic [7:0] delim_nxt;
  logic       wr_en;

  // A write completes in the access phase; the port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    delim_nxt = delim_r;
    if (wr_en && (paddr == bfifo_pkg::CFG_ADDR_DELIM)) begin
      delim_nxt = pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= bfifo_pkg::DELIM_RESET;
    end else begin
      delim_r <= delim_nxt;
    end
  end

  // Read decode.
  always_comb begin
    prdata = 32'd0;
    if (paddr == bfifo_pkg::CFG_ADDR_DELIM) begin
      prdata = {24'd0, delim_r};
    end
  end

  assign delim = delim_r;

endmodule
`default_nettype wire

[hw/rtl/byte_fifo_with_frame_count.sv]
// Top level of the receive byte FIFO with frame counting.
`default_nettype none
// Receive byte FIFO of DEPTH bytes (a power of two) with a count of whole frames
// pending. Each input transfer is a push, a pop or a clear and yields exactly one
// result transfer. Push, clear, a refused operation and an unused code load the
// result when taken; a successful pop first reads the byte from a synchronous
// memory with registered read data and then tests it for the delimiter. A new
// transfer is taken when idle and the result register is empty or being emptied
// in the same cycle, so with the output never stalled the block takes one item
// per cycle except during a successful pop. The delimiter byte lives
// at configuration address 0 and resets to a newline. No clearing pass is needed.
module byte_fifo_with_frame_count #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input channel
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_op,
  input  wire logic [7:0]                       in_write_data,
  // Result channel
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic      [7:0]                       out_read_data,
  output logic                                  out_status,
  output logic      [$clog2(DEPTH):0]           out_fill_level,
  output logic                                  out_is_empty,
  output logic                                  out_is_full,
  output logic      [7:0]                       out_frames_pending,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bfifo_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                      pwdata,
  output logic      [31:0]                      prdata,
  output logic                                  pready
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned PW = AW + 1;

  bfifo_pkg::state_t state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [7:0]    pushed_r, pushed_nxt;
  logic [7:0]    popped_r, popped_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    rd_r;
  logic          status_r;
  logic [PW-1:0] level_r;
  logic          empty_r;
  logic          full_r;
  logic [7:0]    pending_r;

  logic          accept;
  logic          out_take;
  logic          load;
  logic          status_nxt;
  logic [7:0]    rd_nxt;
  logic [PW-1:0] level_cur;
  logic [PW-1:0] level_nxt;
  logic          cur_full;
  logic          cur_empty;
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;
  logic [7:0]    delim;
  bfifo_pkg::op_t op;

  bfifo_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .delim   (delim)
  );

  bfifo_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (wp_r[AW-1:0]),
    .wdata   (in_write_data),
    .re      (ram_re),
    .raddr   (rp_r[AW-1:0]),
    .rdata_r (ram_rdata)
  );

  // Handshake: take a new transfer only when idle and the result slot frees up.
  assign out_take = out_valid_r && !out_stall;
  assign in_stall = !((state_r == bfifo_pkg::ST_IDLE) && (!out_valid_r || !out_stall));
  assign accept   = in_valid && !in_stall;
  assign op       = bfifo_pkg::op_t'(in_op);

  // Fill level from the pointer difference; the top bit alone marks full.
  assign level_cur = wp_r - rp_r;
  assign cur_full  = level_cur[PW-1];
  assign cur_empty = (level_cur == '0);

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfifo_pkg::ST_IDLE: begin
        if (accept && (op == bfifo_pkg::OP_POP) && !cur_empty) begin
          state_nxt = bfifo_pkg::ST_POP;
        end
      end
      bfifo_pkg::ST_POP: begin
        state_nxt = bfifo_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bfifo_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory accesses, pointer and counter updates, and result loading.
  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    pushed_nxt = pushed_r;
    popped_nxt = popped_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load       = 1'b0;
    status_nxt = bfifo_pkg::STATUS_OK;
    rd_nxt     = 8'd0;
    case (state_r)
      bfifo_pkg::ST_IDLE: begin
        if (accept) begin
          load = 1'b1;
          case (op)
            bfifo_pkg::OP_PUSH: begin
              if (cur_full) begin
                status_nxt = bfifo_pkg::STATUS_REFUSED;
              end else begin
                ram_we = 1'b1;
                wp_nxt = wp_r + 1'b1;
                if (in_write_data == delim) begin
                  pushed_nxt = pushed_r + 8'd1;
                end
              end
            end
            bfifo_pkg::OP_POP: begin
              if (cur_empty) begin
                status_nxt = bfifo_pkg::STATUS_REFUSED;
              end else begin
                // The result waits for the memory read in the next cycle.
                ram_re = 1'b1;
                rp_nxt = rp_r + 1'b1;
                load   = 1'b0;
              end
            end
            bfifo_pkg::OP_CLEAR: begin
              rp_nxt     = wp_r;
              popped_nxt = pushed_r;
            end
            default: begin
              status_nxt = bfifo_pkg::STATUS_REFUSED;
            end
          endcase
        end
      end
      bfifo_pkg::ST_POP: begin
        // The popped byte is back from memory: count a delimiter and report it.
        load   = 1'b1;
        rd_nxt = ram_rdata;
        if (ram_rdata == delim) begin
          popped_nxt = popped_r + 8'd1;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign level_nxt     = wp_nxt - rp_nxt;
  assign out_valid_nxt = load || (out_valid_r && !out_take);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfifo_pkg::ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      pushed_r    <= 8'd0;
      popped_r    <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      pushed_r    <= pushed_nxt;
      popped_r    <= popped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load) begin
      rd_r      <= rd_nxt;
      status_r  <= status_nxt;
      level_r   <= level_nxt;
      empty_r   <= (level_nxt == '0);
      full_r    <= level_nxt[PW-1];
      pending_r <= pushed_nxt - popped_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = rd_r;
  assign out_status         = status_r;
  assign out_fill_level     = level_r;
  assign out_is_empty       = empty_r;
  assign out_is_full        = full_r;
  assign out_frames_pending = pending_r;

endmodule
`default_nettype wire
